FILE: rtl/core/s7seq_pkg.sv
`timescale 1ns / 1ps
package s7seq_pkg;

	// sequencer state codes
	localparam logic [3:0] ST_WAIT_X  = 4'd0;
	localparam logic [3:0] ST_COLLECT = 4'd1;
	localparam logic [3:0] ST_WAIT_Y  = 4'd2;
	localparam logic [3:0] ST_SYNC_HI = 4'd3;
	localparam logic [3:0] ST_SYNC_LO = 4'd4;
	localparam logic [3:0] ST_DIG_HI  = 4'd5;
	localparam logic [3:0] ST_DIG_LO  = 4'd6;
	localparam logic [3:0] ST_TRAIL   = 4'd7;

	localparam logic [7:0] CHAR_X = 8'h58;
	localparam logic [7:0] CHAR_Y = 8'h59;

	localparam logic [2:0] FRAME_DATA = 3'd6;
	localparam logic [2:0] TRAIL_X    = 3'd4;
	localparam logic [3:0] CODE_BLANK = 4'd10;

	localparam logic [7:0] PINS_BLANK = 8'h00;

	// segment pattern for a display code; 10 to 15 are blank
	function automatic logic [7:0] seg_pattern(input logic [3:0] code);
		logic [7:0] pat;
		unique case (code)
			4'd0: pat = 8'h77;
			4'd1: pat = 8'h41;
			4'd2: pat = 8'hE6;
			4'd3: pat = 8'hE3;
			4'd4: pat = 8'hD1;
			4'd5: pat = 8'hB3;
			4'd6: pat = 8'hB7;
			4'd7: pat = 8'h61;
			4'd8: pat = 8'hF7;
			4'd9: pat = 8'hF3;
			default: pat = PINS_BLANK;
		endcase
		return pat;
	endfunction

endpackage

FILE: rtl/core/serial_seven_segment_sequencer.sv
`timescale 1ns / 1ps
// Serial seven-segment sequencer.
// Input channel (in_valid/in_ready): one request per timer tick (action 0)
// or per received serial byte (action 1, value on rx_byte).
// Output channel (out_valid/out_ready): one request per tick carrying the
// segment pin levels and the display code in use. Bytes give no output.
// Config: cfg_we/cfg_wdata write the strap digit; it shows at once while no
// frame has yet been accepted.
// Latency: a tick's result is presented the cycle after it is accepted.
// Throughput: one request per cycle while unstalled; all state updates in a
// single pass between the accepted request and the output register.
// The output register holds a result until taken; a new request is taken
// whenever that register is empty or being emptied in the same cycle.
// A receiver stall therefore stalls the input only while a result waits.
// Reset (arst_n low, asynchronous): tick count, state, positions cleared,
// display shows digit 0, output empty. The digit store is not cleared; it
// is always filled by a frame before it is read.
module serial_seven_segment_sequencer
	import s7seq_pkg::*;
#(
	parameter int DIGIT_COUNT = 4,
	parameter int HOLD_BIT    = 5
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] segment_pins,
	output logic [3:0] shown_code,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	localparam int TC_W  = HOLD_BIT + 1;
	localparam int IDX_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [2:0] DIG_CNT = 3'(DIGIT_COUNT);

	logic [TC_W-1:0] tick_count_q, tick_count_d;
	logic [3:0]      display_code_q, display_code_d;
	logic [3:0]      state_q, state_d;
	logic [2:0]      byte_pos_q, byte_pos_d;
	logic [2:0]      step_idx_q, step_idx_d;
	logic            strap_live_q, strap_live_d;
	logic [3:0]      digit_store_q [DIGIT_COUNT];
	logic            dig_we;
	logic [IDX_W-1:0] dig_widx;

	logic            accept, tick_acc, byte_acc;
	logic [TC_W-1:0] tc_inc;
	logic            hi_now, hi_next;
	logic [2:0]      pos_inc, step_inc;
	logic [7:0]      pins;

	assign accept   = in_valid & in_ready;
	assign tick_acc = accept & ~action;
	assign byte_acc = accept & action;
	assign in_ready = ~out_valid | out_ready;

	assign tc_inc   = tick_count_q + 1'b1;
	assign hi_now   = tick_count_q[HOLD_BIT];
	assign hi_next  = tc_inc[HOLD_BIT];
	assign pos_inc  = byte_pos_q + 3'd1;
	assign step_inc = step_idx_q + 3'd1;
	assign dig_widx = byte_pos_q[IDX_W-1:0];

	// pattern on even counts, complement on odd
	always_comb begin
		pins = seg_pattern(display_code_q);
		if (tick_count_q[0]) begin
			pins = ~pins;
		end
	end

	always_comb begin
		tick_count_d   = tick_count_q;
		display_code_d = display_code_q;
		state_d        = state_q;
		byte_pos_d     = byte_pos_q;
		step_idx_d     = step_idx_q;
		strap_live_d   = strap_live_q;
		dig_we         = 1'b0;

		if (tick_acc) begin
			tick_count_d = tc_inc;
			unique case (state_q)
				ST_SYNC_HI: begin
					if (hi_next) begin
						state_d = ST_SYNC_LO;
					end
				end
				ST_SYNC_LO: begin
					if (!hi_next) begin
						step_idx_d = 3'd0;
						state_d    = ST_DIG_HI;
					end
				end
				ST_DIG_HI: begin
					if (hi_next) begin
						display_code_d = (step_idx_q < DIG_CNT)
							? digit_store_q[step_idx_q[IDX_W-1:0]] : CODE_BLANK;
						state_d = ST_DIG_LO;
					end
				end
				ST_DIG_LO: begin
					if (!hi_next) begin
						display_code_d = CODE_BLANK;
						step_idx_d     = step_inc;
						if (step_inc >= DIG_CNT) begin
							byte_pos_d = 3'd0;
							state_d    = ST_TRAIL;
						end else begin
							state_d = ST_DIG_HI;
						end
					end
				end
				default: ;
			endcase
		end else if (byte_acc) begin
			unique case (state_q)
				ST_WAIT_X: begin
					if (rx_byte == CHAR_X) begin
						byte_pos_d = 3'd0;
						state_d    = ST_COLLECT;
					end
				end
				ST_COLLECT: begin
					dig_we     = (byte_pos_q < DIG_CNT);
					byte_pos_d = pos_inc;
					if (pos_inc >= FRAME_DATA) begin
						state_d = ST_WAIT_Y;
					end
				end
				ST_WAIT_Y: begin
					// a bad trailer is consumed, not retried as a start
					if (rx_byte == CHAR_Y) begin
						strap_live_d = 1'b0;
						state_d      = hi_now ? ST_SYNC_LO : ST_SYNC_HI;
					end else begin
						state_d = ST_WAIT_X;
					end
					byte_pos_d = 3'd0;
				end
				ST_TRAIL: begin
					if (rx_byte == CHAR_X) begin
						byte_pos_d = pos_inc;
						if (pos_inc >= TRAIL_X) begin
							byte_pos_d = 3'd0;
							state_d    = ST_WAIT_X;
						end
					end
				end
				default: ; // display phases drop bytes
			endcase
		end

		// strap digit shows directly until the first frame
		if (cfg_we && strap_live_q) begin
			display_code_d = {2'b00, cfg_wdata};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q   <= '0;
			display_code_q <= 4'd0;
			state_q        <= ST_WAIT_X;
			byte_pos_q     <= 3'd0;
			step_idx_q     <= 3'd0;
			strap_live_q   <= 1'b1;
		end else begin
			tick_count_q   <= tick_count_d;
			display_code_q <= display_code_d;
			state_q        <= state_d;
			byte_pos_q     <= byte_pos_d;
			step_idx_q     <= step_idx_d;
			strap_live_q   <= strap_live_d;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_we) begin
			digit_store_q[dig_widx] <= rx_byte[3:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (tick_acc) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_acc) begin
			segment_pins <= pins;
			shown_code   <= display_code_q;
		end
	end

	// ticks advance the count by one, bytes leave it alone
	a_tick_count: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> tick_count_q == TC_W'($past(tick_count_q) + 1'b1))
		else $error("tick count did not advance");

	a_byte_count: assert property (@(posedge clk) disable iff (!arst_n)
		byte_acc |=> $stable(tick_count_q))
		else $error("byte moved tick count");

	a_blank_pins: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && shown_code >= CODE_BLANK) |->
		(segment_pins == 8'h00 || segment_pins == 8'hFF))
		else $error("blank code drove segments");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIG_HI || state_q == ST_DIG_LO) |-> step_idx_q < DIG_CNT)
		else $error("step index out of range during display");

	a_frame_ends_strap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SYNC_HI || state_q == ST_SYNC_LO || state_q == ST_DIG_HI ||
		 state_q == ST_DIG_LO || state_q == ST_TRAIL) |-> !strap_live_q)
		else $error("display sequence with strap digit still live");

endmodule

FILE: tb/sv/tb_serial_seven_segment_sequencer.sv
`timescale 1ns / 1ps
// Self-checking bench for the serial seven-segment sequencer.
// A local display model follows every request taken by the block and
// queues the pin levels each tick should produce; the checker compares
// every result the block hands over against the oldest queued entry.
module tb_serial_seven_segment_sequencer;
	import s7seq_pkg::*;

	localparam int DIGIT_COUNT    = 4;
	localparam int HOLD_BIT       = 5;
	localparam int CLK_HALF       = 5;
	// the last session runs past this, so the total ends above it
	localparam int RANDOM_ITEMS   = 1250;
	localparam int IDLE_PCT       = 24;
	// result shows in the cycle after the request is taken; a little margin on top
	localparam int SETTLE_CYCLES  = 4;
	localparam int END_SLACK      = 8;
	// cycles with no request and no result taken before giving up
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int MAX_PRINTED    = 40;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_BYTE = 1'b1;

	typedef struct packed {
		logic [7:0] pins;
		logic [3:0] code;
	} pin_result_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic       action;
	logic [7:0] rx_byte;
	logic       out_valid;
	logic       out_ready;
	logic [7:0] segment_pins;
	logic [3:0] shown_code;
	logic       cfg_we;
	logic [1:0] cfg_wdata;

	// display model state
	logic [HOLD_BIT:0] mdl_ticks;
	logic [3:0]        mdl_code;
	logic [3:0]        mdl_state;
	logic [2:0]        mdl_pos;
	logic [2:0]        mdl_step;
	logic [3:0]        mdl_digits [DIGIT_COUNT];
	logic [1:0]        mdl_idle;
	logic              mdl_strap;

	pin_result_t expected_pins_q [$];
	pin_result_t head_result;

	logic steady_run;   // both sides stop idling while set
	int   stall_cycles;
	int   mismatch_count;
	int   requests_taken;
	int   ticks_taken;
	int   bytes_taken;
	int   results_checked;
	int   frames_shown;
	int   idle_writes;

	serial_seven_segment_sequencer #(
		.DIGIT_COUNT(DIGIT_COUNT),
		.HOLD_BIT   (HOLD_BIT)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.rx_byte     (rx_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.segment_pins(segment_pins),
		.shown_code  (shown_code),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Display model
	// ------------------------------------------------------------------

	// segment levels for codes 0-9; anything above is a blank digit
	function automatic logic [7:0] digit_segments(input logic [3:0] code);
		case (code)
			4'd0: return 8'h77;
			4'd1: return 8'h41;
			4'd2: return 8'hE6;
			4'd3: return 8'hE3;
			4'd4: return 8'hD1;
			4'd5: return 8'hB3;
			4'd6: return 8'hB7;
			4'd7: return 8'h61;
			4'd8: return 8'hF7;
			4'd9: return 8'hF3;
			default: return 8'h00;
		endcase
	endfunction

	task automatic display_model_reset();
		mdl_ticks = '0;
		mdl_idle  = 2'd0;
		mdl_code  = 4'd0;
		mdl_state = ST_WAIT_X;
		mdl_pos   = 3'd0;
		mdl_step  = 3'd0;
		mdl_strap = 1'b1;
		for (int i = 0; i < DIGIT_COUNT; i++) mdl_digits[i] = 4'd0;
	endtask

	// serial byte: frame parsing and the trailing 'X' count
	task automatic display_model_byte(input logic [7:0] b);
		case (mdl_state)
			ST_WAIT_X: begin
				if (b == CHAR_X) begin
					mdl_pos   = 3'd0;
					mdl_state = ST_COLLECT;
				end
			end
			ST_COLLECT: begin
				if (mdl_pos < DIGIT_COUNT) mdl_digits[mdl_pos] = b[3:0];
				mdl_pos = mdl_pos + 3'd1;
				if (mdl_pos >= FRAME_DATA) mdl_state = ST_WAIT_Y;
			end
			ST_WAIT_Y: begin
				// a wrong end byte is swallowed, not retried as a start
				if (b == CHAR_Y) begin
					mdl_strap = 1'b0;
					frames_shown++;
					mdl_state = mdl_ticks[HOLD_BIT] ? ST_SYNC_LO : ST_SYNC_HI;
				end else begin
					mdl_state = ST_WAIT_X;
				end
				mdl_pos = 3'd0;
			end
			ST_TRAIL: begin
				if (b == CHAR_X) begin
					mdl_pos = mdl_pos + 3'd1;
					if (mdl_pos >= TRAIL_X) begin
						mdl_pos   = 3'd0;
						mdl_state = ST_WAIT_X;
					end
				end
			end
			default: ;  // sync and display phases drop bytes
		endcase
	endtask

	// timer tick: queue the pins, then move the count and the sequence on
	task automatic display_model_tick();
		pin_result_t res;
		logic        hi;
		res.pins = digit_segments(mdl_code);
		if (mdl_ticks[0]) res.pins = ~res.pins;
		res.code = mdl_code;
		expected_pins_q.push_back(res);
		mdl_ticks = mdl_ticks + 1'b1;
		hi = mdl_ticks[HOLD_BIT];
		case (mdl_state)
			ST_SYNC_HI: if (hi) mdl_state = ST_SYNC_LO;
			ST_SYNC_LO: begin
				if (!hi) begin
					mdl_step  = 3'd0;
					mdl_state = ST_DIG_HI;
				end
			end
			ST_DIG_HI: begin
				if (hi) begin
					mdl_code  = (mdl_step < DIGIT_COUNT) ? mdl_digits[mdl_step] : CODE_BLANK;
					mdl_state = ST_DIG_LO;
				end
			end
			ST_DIG_LO: begin
				if (!hi) begin
					mdl_code = CODE_BLANK;
					mdl_step = mdl_step + 3'd1;
					if (mdl_step >= DIGIT_COUNT) begin
						mdl_pos   = 3'd0;
						mdl_state = ST_TRAIL;
					end else begin
						mdl_state = ST_DIG_HI;
					end
				end
			end
			default: ;
		endcase
	endtask

	// follow register writes and taken requests at each edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				mdl_idle = cfg_wdata;
				if (mdl_strap) mdl_code = {2'b00, mdl_idle};
			end
			if (in_valid && in_ready) begin
				requests_taken++;
				if (action == ACT_BYTE) begin
					bytes_taken++;
					display_model_byte(rx_byte);
				end else begin
					ticks_taken++;
					display_model_tick();
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTED)
			$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $time);
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_pins_q.size() == 0) begin
				report_mismatch("result with no tick outstanding", segment_pins, 0);
			end else begin
				head_result = expected_pins_q.pop_front();
				results_checked++;
				if (segment_pins !== head_result.pins)
					report_mismatch("segment_pins", segment_pins, head_result.pins);
				if (shown_code !== head_result.code)
					report_mismatch("shown_code", shown_code, head_result.code);
			end
		end
	end

	// receiver: stalls about a quarter of the cycles unless steady_run
	always @(posedge clk) begin
		out_ready <= steady_run || ($urandom_range(99) >= IDLE_PCT);
	end

	// watchdog on forward progress of either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// one request; random idle cycles first, then hold until taken
	task automatic send_request(input logic act, input logic [7:0] b);
		while (!steady_run && ($urandom_range(99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		rx_byte  <= b;
		do @(posedge clk); while (!in_ready);
	endtask

	// rx_byte carries junk on ticks; the block must ignore it
	task automatic send_tick();
		send_request(ACT_TICK, 8'($urandom_range(255)));
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_request(ACT_BYTE, b);
	endtask

	// random byte, leaning on the framing characters now and then
	function automatic logic [7:0] noise_byte();
		case ($urandom_range(7))
			0: return CHAR_X;
			1: return CHAR_Y;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// hold the sender off until every outstanding tick has its result
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_pins_q.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_idle_digit(input logic [1:0] value);
		wait_drained();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		idle_writes++;
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// strap digit shows straight away before any frame; both tick parities
	task automatic test_idle_digit_display();
		write_idle_digit(2'd3);
		repeat (2) send_tick();
		write_idle_digit(2'd0);
		repeat (2) send_tick();
		write_idle_digit(2'd2);
		repeat (2) send_tick();
		write_idle_digit(2'd1);
		repeat (2) send_tick();
	endtask

	// frame with extreme bytes but the wrong end character: discarded,
	// and that 'X' must not open a new frame, so the 'Y' after it is noise
	task automatic test_bad_frame_end();
		send_byte(CHAR_X);
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		send_byte(8'hA5);
		send_byte(8'h0F);
		send_byte(8'hF0);
		send_byte(CHAR_X);
		send_byte(CHAR_Y);
		send_tick();
	endtask

	// ticks that carry framing characters on rx_byte
	task automatic test_tick_ignores_byte();
		send_request(ACT_TICK, CHAR_X);
		send_request(ACT_TICK, CHAR_Y);
		send_request(ACT_TICK, 8'hFF);
		send_request(ACT_TICK, 8'h00);
	endtask

	// one frame attempt followed through display and trailing 'X' bytes
	task automatic run_frame_session();
		int pre_ticks;
		pre_ticks = $urandom_range(40);
		// loose noise while waiting for a start character
		repeat ($urandom_range(3)) begin
			if ($urandom_range(1)) send_tick();
			else send_byte(noise_byte());
		end
		// vary the count phase so 'Y' lands on both halves of the hold bit
		repeat (pre_ticks) send_tick();
		send_byte(CHAR_X);
		repeat (FRAME_DATA) begin
			if ($urandom_range(99) < 20) send_tick();
			send_byte(8'($urandom_range(255)));
		end
		if ($urandom_range(99) < 80) send_byte(CHAR_Y);
		else send_byte(noise_byte());
		send_tick();
		// sync and digit phases: mostly ticks, some bytes to be dropped
		while (mdl_state >= ST_SYNC_HI && mdl_state <= ST_DIG_LO) begin
			if ($urandom_range(99) < 90) send_tick();
			else send_byte(noise_byte());
		end
		while (mdl_state == ST_TRAIL) begin
			case ($urandom_range(4))
				0: send_tick();
				1: send_byte(noise_byte());
				default: send_byte(CHAR_X);
			endcase
		end
	endtask

	task automatic test_random_frames();
		int target;
		int session;
		target  = requests_taken + RANDOM_ITEMS;
		session = 0;
		while (requests_taken < target) begin
			// one session runs flat out on both sides
			steady_run = (session == 1);
			run_frame_session();
			steady_run = 1'b0;
			// after every third session: drain fully and move the strap digit
			if (session % 3 == 2) write_idle_digit(2'($urandom_range(3)));
			session++;
		end
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		action     <= ACT_TICK;
		rx_byte    <= 8'h00;
		cfg_we     <= 1'b0;
		cfg_wdata  <= 2'd0;
		out_ready  <= 1'b0;
		steady_run = 1'b0;
		stall_cycles    = 0;
		mismatch_count  = 0;
		requests_taken  = 0;
		ticks_taken     = 0;
		bytes_taken     = 0;
		results_checked = 0;
		frames_shown    = 0;
		idle_writes     = 0;
		display_model_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_idle_digit_display();
		test_bad_frame_end();
		test_tick_ignores_byte();
		test_random_frames();

		wait_drained();
		repeat (END_SLACK) @(posedge clk);
		if (expected_pins_q.size() != 0)
			report_mismatch("ticks left without a result", expected_pins_q.size(), 0);

		$display("Run covered %0d requests (%0d ticks, %0d bytes), %0d results checked",
			requests_taken, ticks_taken, bytes_taken, results_checked);
		$display("Frames displayed: %0d, strap digit writes: %0d, mismatches: %0d",
			frames_shown, idle_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/s7seq_pkg.sv
rtl/core/serial_seven_segment_sequencer.sv
tb/sv/tb_serial_seven_segment_sequencer.sv
